// ----- rtl/bfg_pkg.sv -----
// ============================================================================
// Fuel gauge package
// Shared widths, register indexes, beat types and the cell discharge curve.
// ============================================================================
package bfg_pkg;

    localparam int TIME_W    = 32;
    localparam int CUR_W     = 20;
    localparam int CAP_W     = 16;
    localparam int MV_W      = 16;
    localparam int CELL_W    = 5;
    localparam int STABLE_W  = 24;
    localparam int SOC_W     = 7;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    // Charge integration works in mA*ms; one mAh is 3600000 of them.
    localparam int MAMS_W   = 22;
    localparam int MAMS_LOG = 21;
    localparam logic [MAMS_W-1:0] MAMS_PER_MAH = MAMS_W'(3600000);

    localparam int DIV_W  = CUR_W + MAMS_W;
    localparam int DIVS_W = MAMS_W;
    localparam int MA_W   = CUR_W;
    localparam int Q_W    = TIME_W - MAMS_LOG;
    localparam int CQ_W   = CUR_W + Q_W;
    localparam int DM_W   = CQ_W + 1;

    localparam int CURVE_N = 22;
    localparam int SEG_W   = 5;
    localparam logic [MV_W-1:0]  CURVE_TOP_MV = MV_W'(4200);
    localparam logic [SOC_W-1:0] SOC_FULL     = SOC_W'(100);

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MV    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MV    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_RECAL_MA  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_RECAL_MS  = CFG_IDX_W'(5);

    typedef struct packed {
        logic              command;
        logic [TIME_W-1:0] timestamp_ms;
        logic              current_available;
        logic              telemetry_valid;
        logic [CUR_W-1:0]  current_ma;
        logic [MV_W-1:0]   pack_mv;
    } in_t;

    typedef struct packed {
        logic [SOC_W-1:0] soc_percent;
        logic [SOC_W-1:0] voltage_soc_percent;
        logic [CAP_W-1:0] remaining_mah;
        logic [CAP_W-1:0] consumed_mah;
    } out_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quot;
        logic [DIVS_W-1:0] rem;
    } div_res_t;

    typedef struct packed {
        logic             found;
        logic [SEG_W-1:0] idx;
    } seg_t;

    function automatic logic [MV_W-1:0] curve_mv(input logic [SEG_W-1:0] i);
        logic [MV_W-1:0] v;
        case (i)
            5'd0:    v = MV_W'(4200);
            5'd1:    v = MV_W'(4175);
            5'd2:    v = MV_W'(4150);
            5'd3:    v = MV_W'(4125);
            5'd4:    v = MV_W'(4100);
            5'd5:    v = MV_W'(4075);
            5'd6:    v = MV_W'(4050);
            5'd7:    v = MV_W'(4000);
            5'd8:    v = MV_W'(3950);
            5'd9:    v = MV_W'(3900);
            5'd10:   v = MV_W'(3850);
            5'd11:   v = MV_W'(3800);
            5'd12:   v = MV_W'(3750);
            5'd13:   v = MV_W'(3700);
            5'd14:   v = MV_W'(3650);
            5'd15:   v = MV_W'(3600);
            5'd16:   v = MV_W'(3550);
            5'd17:   v = MV_W'(3500);
            5'd18:   v = MV_W'(3450);
            5'd19:   v = MV_W'(3400);
            5'd20:   v = MV_W'(3300);
            5'd21:   v = MV_W'(3200);
            default: v = MV_W'(3200);
        endcase
        return v;
    endfunction

    function automatic logic [SOC_W-1:0] curve_soc(input logic [SEG_W-1:0] i);
        logic [SOC_W-1:0] v;
        case (i)
            5'd0:    v = SOC_W'(100);
            5'd1:    v = SOC_W'(99);
            5'd2:    v = SOC_W'(97);
            5'd3:    v = SOC_W'(94);
            5'd4:    v = SOC_W'(91);
            5'd5:    v = SOC_W'(88);
            5'd6:    v = SOC_W'(87);
            5'd7:    v = SOC_W'(85);
            5'd8:    v = SOC_W'(79);
            5'd9:    v = SOC_W'(72);
            5'd10:   v = SOC_W'(64);
            5'd11:   v = SOC_W'(56);
            5'd12:   v = SOC_W'(48);
            5'd13:   v = SOC_W'(40);
            5'd14:   v = SOC_W'(32);
            5'd15:   v = SOC_W'(24);
            5'd16:   v = SOC_W'(17);
            5'd17:   v = SOC_W'(11);
            5'd18:   v = SOC_W'(6);
            5'd19:   v = SOC_W'(3);
            5'd20:   v = SOC_W'(1);
            5'd21:   v = SOC_W'(0);
            default: v = SOC_W'(0);
        endcase
        return v;
    endfunction

    // The first curve segment that holds the cell voltage wins.
    function automatic seg_t seg_find(input logic [MV_W-1:0] cell_mv);
        seg_t s;
        s.found = 1'b0;
        s.idx   = '0;
        for (int i = CURVE_N - 2; i >= 0; i--) begin
            if (cell_mv >= curve_mv(SEG_W'(i + 1)) && cell_mv <= curve_mv(SEG_W'(i))) begin
                s.found = 1'b1;
                s.idx   = SEG_W'(i);
            end
        end
        return s;
    endfunction

endpackage

// ----- rtl/bfg_div.sv -----
// ============================================================================
// Fuel gauge divider
// Restoring divider that retires one quotient bit per cycle.
// ============================================================================
module bfg_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [bfg_pkg::DIV_W-1:0]  dividend,
    input  logic [bfg_pkg::DIVS_W-1:0] divisor,
    output bfg_pkg::div_res_t          res
);
    import bfg_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  quot_reg, quot_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              ge;

    always_comb begin
        trial = {rem_reg, quot_reg[DIV_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = trial >= {1'b0, dvs_reg};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            quot_next = {quot_reg[DIV_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;
    assign res.rem  = rem_reg;

endmodule

// ----- rtl/battery_coulomb_fuel_gauge.sv -----
// ============================================================================
// Battery coulomb fuel gauge
// Coulomb counter with voltage recalibration and usable-window reporting.
// ============================================================================
// Each input beat is either a measurement tick or a refill command. The gauge
// integrates current over the time since the last tick, keeps the fraction
// of a mAh as a remainder and blends in a voltage estimate after the first
// tick and after a stable idle window. Every input beat yields one result
// beat with the state of charge, the voltage-only state of charge, the usable
// remaining charge and the consumed charge.
// A single shared divider that produces one quotient bit per cycle does up to
// twelve 42-bit divisions per item. One item is in work at a time; s_ready is
// high while the sequencer is idle, and a new item is accepted while a
// finished result waits in the output register. When the receiver stalls, the
// next result waits in the sequencer until the output register is free.
// Configuration writes take effect at once; the user must make them while the
// gauge is idle, which the block does not enforce. Writing the capacity
// refills the gauge. Reset clears the charge and timing state and loads the
// register reset values.
// ============================================================================
module battery_coulomb_fuel_gauge (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  bfg_pkg::in_t                 s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output bfg_pkg::out_t                m_data,
    input  logic                         cfg_we,
    input  logic [bfg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bfg_pkg::CFG_W-1:0]     cfg_data
);
    import bfg_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_LK_GO, S_LK_WT, S_IN_GO, S_IN_WT, S_LK_NEXT, S_SC, S_SC_GO,
        S_SC_WT, S_US, S_R_GO, S_R_WT, S_U_GO, S_U_WT, S_UPD, S_V_GO, S_V_WT,
        S_B_GO, S_B_WT, S_DT_GO, S_DT_WT, S_PT_GO, S_PT_WT, S_FIN, S_SO_GO,
        S_SO_WT, S_OUT
    } state_t;

    state_t st_reg, st_next;

    logic [CAP_W-1:0]    cap_reg, cap_next;
    logic [MV_W-1:0]     minmv_reg, minmv_next;
    logic [MV_W-1:0]     maxmv_reg, maxmv_next;
    logic [CELL_W-1:0]   cells_reg, cells_next;
    logic [CUR_W-1:0]    thr_reg, thr_next;
    logic [STABLE_W-1:0] stable_reg, stable_next;

    logic [CAP_W-1:0]  charge_reg, charge_next;
    logic [TIME_W-1:0] last_reg, last_next;
    logic [MAMS_W-1:0] chrem_reg, chrem_next;
    logic [TIME_W-1:0] idle_reg, idle_next;

    in_t              item_reg, item_next;
    logic [1:0]       lk_sel_reg, lk_sel_next;
    logic [SOC_W-1:0] lk_val_reg, lk_val_next;
    logic [MV_W-1:0]  cell_reg, cell_next;
    logic [SEG_W-1:0] seg_reg, seg_next;
    logic [SOC_W-1:0] smin_reg, smin_next;
    logic [SOC_W-1:0] smax_reg, smax_next;
    logic [SOC_W-1:0] sa_reg, sa_next;
    logic [SOC_W-1:0] vs_reg, vs_next;
    logic [CAP_W-1:0] r_reg, r_next;
    logic [CAP_W-1:0] u_reg, u_next;
    logic [CAP_W-1:0] vrem_reg, vrem_next;
    logic [MAMS_W-1:0] dtr_reg, dtr_next;
    logic [CQ_W-1:0]  curq_reg, curq_next;
    logic [CAP_W-1:0] urem_reg, urem_next;
    logic [SOC_W-1:0] soc_reg, soc_next;
    logic [CAP_W-1:0] remout_reg, remout_next;
    logic             m_valid_reg, m_valid_next;
    out_t             m_data_reg, m_data_next;

    logic [CELL_W-1:0] cells_eff;
    logic [MV_W-1:0]   win_lo, win_hi, lk_v;
    logic [MV_W-1:0]   seg_hi, seg_lo;
    logic [SOC_W-1:0]  seg_drop;
    seg_t              fnd;
    logic [TIME_W-1:0] age, dt;
    logic [DM_W-1:0]   dmah;
    logic [CAP_W:0]    vsum;
    logic [CAP_W-1:0]  cap_left, urem_c, new_charge;
    logic [SOC_W-1:0]  vs_out;

    logic              div_start, op_direct;
    logic [MA_W-1:0]   op_a;
    logic [MAMS_W-1:0] op_b, op_add;
    logic [DIVS_W-1:0] op_div;
    logic [DIV_W-1:0]  prod, dividend;
    div_res_t          div_res;

    bfg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (op_div),
        .res      (div_res)
    );

    assign cells_eff = (cells_reg == '0) ? CELL_W'(1) : cells_reg;
    assign win_lo    = (maxmv_reg < minmv_reg) ? maxmv_reg : minmv_reg;
    assign win_hi    = (maxmv_reg < minmv_reg) ? minmv_reg : maxmv_reg;
    assign lk_v      = (lk_sel_reg == 2'd0) ? win_lo :
                       (lk_sel_reg == 2'd1) ? win_hi : item_reg.pack_mv;
    assign seg_hi    = curve_mv(seg_reg);
    assign seg_lo    = curve_mv(seg_reg + SEG_W'(1));
    assign seg_drop  = curve_soc(seg_reg) - curve_soc(seg_reg + SEG_W'(1));
    assign fnd       = seg_find(div_res.quot[MV_W-1:0]);
    assign age       = item_reg.timestamp_ms - idle_reg;
    assign dt        = item_reg.timestamp_ms - last_reg;
    assign dmah      = DM_W'(curq_reg) + div_res.quot[DM_W-1:0];
    assign vsum      = {1'b0, r_reg} + {1'b0, div_res.quot[CAP_W-1:0]};
    assign cap_left  = cap_reg - r_reg;
    assign vs_out    = item_reg.telemetry_valid ? vs_reg : '0;
    assign urem_c    = (charge_reg <= r_reg) ? '0 :
                       ((charge_reg - r_reg) > u_reg) ? u_reg : (charge_reg - r_reg);
    assign new_charge = (dmah <= DM_W'(charge_reg)) ?
                        (charge_reg - dmah[CAP_W-1:0]) : '0;

    assign prod     = DIV_W'(op_a) * DIV_W'(op_b);
    assign dividend = op_direct ? DIV_W'(dt) : (prod + DIV_W'(op_add));

    always_comb begin
        div_start = 1'b0;
        op_direct = 1'b0;
        op_a      = '0;
        op_b      = '0;
        op_add    = '0;
        op_div    = DIVS_W'(1);
        case (st_reg)
            S_LK_GO: begin
                div_start = 1'b1;
                op_a      = MA_W'(lk_v);
                op_b      = MAMS_W'(1);
                op_div    = DIVS_W'(cells_eff);
            end
            S_IN_GO: begin
                div_start = 1'b1;
                op_a      = MA_W'(seg_hi - cell_reg);
                op_b      = MAMS_W'(seg_drop);
                op_div    = DIVS_W'(seg_hi - seg_lo);
            end
            S_SC_GO: begin
                div_start = 1'b1;
                op_a      = MA_W'(sa_reg - smin_reg);
                op_b      = MAMS_W'(SOC_FULL);
                op_div    = DIVS_W'(smax_reg - smin_reg);
            end
            S_R_GO: begin
                div_start = 1'b1;
                op_a      = MA_W'(cap_reg);
                op_b      = MAMS_W'(smin_reg);
                op_div    = DIVS_W'(SOC_FULL);
            end
            S_U_GO: begin
                div_start = 1'b1;
                op_a      = MA_W'(cap_reg);
                op_b      = MAMS_W'(smax_reg - smin_reg);
                op_div    = DIVS_W'(SOC_FULL);
            end
            S_V_GO: begin
                div_start = 1'b1;
                op_a      = MA_W'(vs_reg);
                op_b      = MAMS_W'(u_reg);
                op_div    = DIVS_W'(SOC_FULL);
            end
            S_B_GO: begin
                div_start = 1'b1;
                op_a      = MA_W'(charge_reg);
                op_b      = MAMS_W'(9);
                op_add    = MAMS_W'(vrem_reg);
                op_div    = DIVS_W'(10);
            end
            S_DT_GO: begin
                div_start = 1'b1;
                op_direct = 1'b1;
                op_div    = MAMS_PER_MAH;
            end
            S_PT_GO: begin
                div_start = 1'b1;
                op_a      = item_reg.current_ma;
                op_b      = dtr_reg;
                op_add    = chrem_reg;
                op_div    = MAMS_PER_MAH;
            end
            S_SO_GO: begin
                div_start = 1'b1;
                if (item_reg.current_available) begin
                    op_a   = MA_W'(urem_reg);
                    op_b   = MAMS_W'(SOC_FULL);
                    op_div = DIVS_W'(u_reg);
                end else begin
                    op_a   = MA_W'(u_reg);
                    op_b   = MAMS_W'(soc_reg);
                    op_div = DIVS_W'(SOC_FULL);
                end
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        st_next      = st_reg;
        cap_next     = cap_reg;
        minmv_next   = minmv_reg;
        maxmv_next   = maxmv_reg;
        cells_next   = cells_reg;
        thr_next     = thr_reg;
        stable_next  = stable_reg;
        charge_next  = charge_reg;
        last_next    = last_reg;
        chrem_next   = chrem_reg;
        idle_next    = idle_reg;
        item_next    = item_reg;
        lk_sel_next  = lk_sel_reg;
        lk_val_next  = lk_val_reg;
        cell_next    = cell_reg;
        seg_next     = seg_reg;
        smin_next    = smin_reg;
        smax_next    = smax_reg;
        sa_next      = sa_reg;
        vs_next      = vs_reg;
        r_next       = r_reg;
        u_next       = u_reg;
        vrem_next    = vrem_reg;
        dtr_next     = dtr_reg;
        curq_next    = curq_reg;
        urem_next    = urem_reg;
        soc_next     = soc_reg;
        remout_next  = remout_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (st_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next   = s_data;
                    lk_sel_next = 2'd0;
                    st_next     = S_LK_GO;
                end
            end
            S_LK_GO: st_next = S_LK_WT;
            S_LK_WT: begin
                if (div_res.done) begin
                    cell_next = div_res.quot[MV_W-1:0];
                    seg_next  = fnd.idx;
                    if (fnd.found) begin
                        st_next = S_IN_GO;
                    end else begin
                        lk_val_next = (div_res.quot[MV_W-1:0] > CURVE_TOP_MV) ? SOC_FULL : '0;
                        st_next     = S_LK_NEXT;
                    end
                end
            end
            S_IN_GO: st_next = S_IN_WT;
            S_IN_WT: begin
                if (div_res.done) begin
                    lk_val_next = curve_soc(seg_reg) - div_res.quot[SOC_W-1:0];
                    st_next     = S_LK_NEXT;
                end
            end
            S_LK_NEXT: begin
                case (lk_sel_reg)
                    2'd0: begin
                        smin_next   = lk_val_reg;
                        lk_sel_next = 2'd1;
                        st_next     = S_LK_GO;
                    end
                    2'd1: begin
                        smax_next   = (lk_val_reg < smin_reg) ? smin_reg : lk_val_reg;
                        lk_sel_next = 2'd2;
                        st_next     = S_LK_GO;
                    end
                    default: begin
                        sa_next = lk_val_reg;
                        st_next = S_SC;
                    end
                endcase
            end
            S_SC: begin
                if (smax_reg <= smin_reg || sa_reg <= smin_reg) begin
                    vs_next = '0;
                    st_next = S_US;
                end else if (sa_reg >= smax_reg) begin
                    vs_next = SOC_FULL;
                    st_next = S_US;
                end else begin
                    st_next = S_SC_GO;
                end
            end
            S_SC_GO: st_next = S_SC_WT;
            S_SC_WT: begin
                if (div_res.done) begin
                    vs_next = div_res.quot[SOC_W-1:0];
                    st_next = S_US;
                end
            end
            S_US: begin
                if (cap_reg == '0) begin
                    r_next  = '0;
                    u_next  = '0;
                    st_next = S_UPD;
                end else begin
                    st_next = S_R_GO;
                end
            end
            S_R_GO: st_next = S_R_WT;
            S_R_WT: begin
                if (div_res.done) begin
                    r_next  = (div_res.quot > DIV_W'(cap_reg)) ? cap_reg :
                              div_res.quot[CAP_W-1:0];
                    st_next = S_U_GO;
                end
            end
            S_U_GO: st_next = S_U_WT;
            S_U_WT: begin
                if (div_res.done) begin
                    u_next  = (div_res.quot > DIV_W'(cap_left)) ? cap_left :
                              div_res.quot[CAP_W-1:0];
                    st_next = S_UPD;
                end
            end
            S_UPD: begin
                if (item_reg.command) begin
                    charge_next = cap_reg;
                    chrem_next  = '0;
                    idle_next   = '0;
                    st_next     = S_FIN;
                end else if (!item_reg.current_available) begin
                    last_next = item_reg.timestamp_ms;
                    idle_next = '0;
                    st_next   = S_FIN;
                end else if (last_reg == '0) begin
                    last_next = item_reg.timestamp_ms;
                    idle_next = '0;
                    st_next   = item_reg.telemetry_valid ? S_V_GO : S_FIN;
                end else if (item_reg.current_ma <= thr_reg) begin
                    if (idle_reg == '0) begin
                        idle_next = item_reg.timestamp_ms;
                        st_next   = S_DT_GO;
                    end else if (age >= TIME_W'(stable_reg)) begin
                        chrem_next = '0;
                        last_next  = item_reg.timestamp_ms;
                        idle_next  = item_reg.timestamp_ms;
                        st_next    = item_reg.telemetry_valid ? S_V_GO : S_FIN;
                    end else begin
                        st_next = S_DT_GO;
                    end
                end else begin
                    idle_next = '0;
                    st_next   = S_DT_GO;
                end
            end
            S_V_GO: st_next = S_V_WT;
            S_V_WT: begin
                if (div_res.done) begin
                    vrem_next = (vsum > {1'b0, cap_reg}) ? cap_reg : vsum[CAP_W-1:0];
                    st_next   = S_B_GO;
                end
            end
            S_B_GO: st_next = S_B_WT;
            S_B_WT: begin
                if (div_res.done) begin
                    charge_next = (div_res.quot > DIV_W'(cap_reg)) ? cap_reg :
                                  div_res.quot[CAP_W-1:0];
                    st_next     = S_FIN;
                end
            end
            S_DT_GO: st_next = S_DT_WT;
            S_DT_WT: begin
                if (div_res.done) begin
                    dtr_next  = div_res.rem;
                    curq_next = CQ_W'(item_reg.current_ma) * CQ_W'(div_res.quot[Q_W-1:0]);
                    st_next   = S_PT_GO;
                end
            end
            S_PT_GO: st_next = S_PT_WT;
            S_PT_WT: begin
                if (div_res.done) begin
                    chrem_next  = div_res.rem;
                    charge_next = (new_charge > cap_reg) ? cap_reg : new_charge;
                    last_next   = item_reg.timestamp_ms;
                    st_next     = S_FIN;
                end
            end
            S_FIN: begin
                urem_next = urem_c;
                if (item_reg.current_available) begin
                    remout_next = urem_c;
                    if (u_reg == '0) begin
                        soc_next = '0;
                        st_next  = S_OUT;
                    end else begin
                        st_next = S_SO_GO;
                    end
                end else begin
                    soc_next = vs_out;
                    st_next  = S_SO_GO;
                end
            end
            S_SO_GO: st_next = S_SO_WT;
            S_SO_WT: begin
                if (div_res.done) begin
                    if (item_reg.current_available) begin
                        soc_next = (div_res.quot > DIV_W'(SOC_FULL)) ? SOC_FULL :
                                   div_res.quot[SOC_W-1:0];
                    end else begin
                        remout_next = div_res.quot[CAP_W-1:0];
                    end
                    st_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.soc_percent         = soc_reg;
                    m_data_next.voltage_soc_percent = vs_out;
                    m_data_next.remaining_mah       = remout_reg;
                    m_data_next.consumed_mah        = (u_reg == '0) ? '0 : (u_reg - urem_reg);
                    m_valid_next = 1'b1;
                    st_next      = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase

        if (cfg_we) begin
            case (cfg_index)
                CFG_CAPACITY: begin
                    cap_next    = cfg_data[CAP_W-1:0];
                    charge_next = cfg_data[CAP_W-1:0];
                    chrem_next  = '0;
                    idle_next   = '0;
                end
                CFG_MIN_MV:   minmv_next  = cfg_data[MV_W-1:0];
                CFG_MAX_MV:   maxmv_next  = cfg_data[MV_W-1:0];
                CFG_CELLS:    cells_next  = cfg_data[CELL_W-1:0];
                CFG_RECAL_MA: thr_next    = cfg_data[CUR_W-1:0];
                CFG_RECAL_MS: stable_next = cfg_data[STABLE_W-1:0];
                default:      cap_next    = cap_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        lk_sel_reg <= lk_sel_next;
        lk_val_reg <= lk_val_next;
        cell_reg   <= cell_next;
        seg_reg    <= seg_next;
        smin_reg   <= smin_next;
        smax_reg   <= smax_next;
        sa_reg     <= sa_next;
        vs_reg     <= vs_next;
        r_reg      <= r_next;
        u_reg      <= u_next;
        vrem_reg   <= vrem_next;
        dtr_reg    <= dtr_next;
        curq_reg   <= curq_next;
        urem_reg   <= urem_next;
        soc_reg    <= soc_next;
        remout_reg <= remout_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            st_reg      <= S_IDLE;
            m_valid_reg <= 1'b0;
            cap_reg     <= '0;
            minmv_reg   <= '0;
            maxmv_reg   <= '1;
            cells_reg   <= CELL_W'(1);
            thr_reg     <= '0;
            stable_reg  <= STABLE_W'(5000);
            charge_reg  <= '0;
            last_reg    <= '0;
            chrem_reg   <= '0;
            idle_reg    <= '0;
        end else begin
            st_reg      <= st_next;
            m_valid_reg <= m_valid_next;
            cap_reg     <= cap_next;
            minmv_reg   <= minmv_next;
            maxmv_reg   <= maxmv_next;
            cells_reg   <= cells_next;
            thr_reg     <= thr_next;
            stable_reg  <= stable_next;
            charge_reg  <= charge_next;
            last_reg    <= last_next;
            chrem_reg   <= chrem_next;
            idle_reg    <= idle_next;
        end
    end

    assign s_ready = (st_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- tb/tb_top.sv -----
// ============================================================================
// Fuel gauge testbench
// A directed table and then random phases of ticks drive the gauge through
// valid/ready bursts while the result side stalls at random. Each accepted
// beat is run through a local coulomb-counting predictor, and every result
// beat is compared field by field with the oldest expected result.
// ============================================================================
`timescale 1ns / 100ps

module tb_top;
    import bfg_pkg::*;

    localparam int RUN_LIMIT = 4000000;
    localparam int SETTLE    = 700;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     val;
        in_t                  beat;
        bit                   typed;
        out_t                 want;
    } row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_t                  s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_t                 m_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_CAPACITY;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Gauge state as the predictor sees it.
    int unsigned     g_cap, g_min_mv, g_max_mv, g_cells, g_idle_ma, g_idle_ms;
    int unsigned     g_charge;
    longint unsigned g_last_ms, g_frac, g_idle_at;

    int unsigned lipo_mv [0:21] = '{4200, 4175, 4150, 4125, 4100, 4075, 4050, 4000,
                                    3950, 3900, 3850, 3800, 3750, 3700, 3650, 3600,
                                    3550, 3500, 3450, 3400, 3300, 3200};
    int unsigned lipo_soc [0:21] = '{100, 99, 97, 94, 91, 88, 87, 85, 79, 72, 64,
                                     56, 48, 40, 32, 24, 17, 11, 6, 3, 1, 0};

    out_t pending_reports[$];
    int   mismatches = 0;
    int   reports_seen = 0;
    int   beats_sent = 0;
    int   refills = 0;
    int   cycles = 0;
    int   phases_run = 0;

    battery_coulomb_fuel_gauge dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned cell_level(input int unsigned pack);
        int unsigned cells;
        int unsigned cell_mv;
        cells = (g_cells == 0) ? 1 : g_cells;
        cell_mv = pack / cells;
        for (int i = 0; i < 21; i++) begin
            if (cell_mv >= lipo_mv[i+1] && cell_mv <= lipo_mv[i]) begin
                return lipo_soc[i] - ((lipo_mv[i] - cell_mv) * (lipo_soc[i] - lipo_soc[i+1]))
                       / (lipo_mv[i] - lipo_mv[i+1]);
            end
        end
        return (cell_mv > 4200) ? 100 : 0;
    endfunction

    function automatic void window_levels(output int unsigned lo_soc,
                                          output int unsigned hi_soc);
        int unsigned lo, hi;
        lo = g_min_mv;
        hi = g_max_mv;
        if (hi < lo) begin
            lo = g_max_mv;
            hi = g_min_mv;
        end
        lo_soc = cell_level(lo);
        hi_soc = cell_level(hi);
        if (hi_soc < lo_soc) hi_soc = lo_soc;
    endfunction

    function automatic int unsigned window_soc(input int unsigned pack);
        int unsigned lo_soc, hi_soc, a;
        window_levels(lo_soc, hi_soc);
        if (hi_soc <= lo_soc) return 0;
        a = cell_level(pack);
        if (a <= lo_soc) return 0;
        if (a >= hi_soc) return 100;
        return ((a - lo_soc) * 100) / (hi_soc - lo_soc);
    endfunction

    function automatic void split_capacity(output int unsigned reserve,
                                           output int unsigned usable);
        int unsigned lo_soc, hi_soc;
        reserve = 0;
        usable = 0;
        if (g_cap != 0) begin
            window_levels(lo_soc, hi_soc);
            reserve = (g_cap * lo_soc) / 100;
            usable = (g_cap * (hi_soc - lo_soc)) / 100;
            if (reserve > g_cap) reserve = g_cap;
            if (usable > g_cap - reserve) usable = g_cap - reserve;
        end
    endfunction

    function automatic void blend_voltage(input bit tv, input int unsigned pack);
        int unsigned reserve, usable, vrem;
        if (tv) begin
            split_capacity(reserve, usable);
            vrem = reserve + (window_soc(pack) * usable) / 100;
            if (vrem > g_cap) vrem = g_cap;
            g_charge = (g_charge * 9 + vrem) / 10;
            if (g_charge > g_cap) g_charge = g_cap;
        end
    endfunction

    function automatic void count_charge(input in_t b);
        longint unsigned ts, cur, dt, whole, part, dmah;
        ts = b.timestamp_ms;
        cur = b.current_ma;
        if (!b.current_available) begin
            g_last_ms = ts;
            g_idle_at = 0;
            return;
        end
        if (g_last_ms == 0) begin
            g_last_ms = ts;
            g_idle_at = 0;
            blend_voltage(b.telemetry_valid, b.pack_mv);
            return;
        end
        if (cur <= g_idle_ma) begin
            if (g_idle_at == 0) begin
                g_idle_at = ts;
            end else if (((ts - g_idle_at) & 64'hFFFF_FFFF) >= g_idle_ms) begin
                blend_voltage(b.telemetry_valid, b.pack_mv);
                g_frac = 0;
                g_last_ms = ts;
                g_idle_at = ts;
                return;
            end
        end else begin
            g_idle_at = 0;
        end
        dt = (ts - g_last_ms) & 64'hFFFF_FFFF;
        whole = dt / 3600000;
        dmah = cur * whole;
        part = cur * (dt % 3600000) + g_frac;
        g_frac = part % 3600000;
        dmah = dmah + part / 3600000;
        if (dmah <= g_charge) g_charge = g_charge - int'(dmah);
        else g_charge = 0;
        if (g_charge > g_cap) g_charge = g_cap;
        g_last_ms = ts;
    endfunction

    function automatic out_t gauge_predict(input in_t b);
        int unsigned reserve, usable, urem, vsoc, soc, rem, cons;
        out_t r;
        if (b.command) begin
            g_charge = g_cap;
            g_frac = 0;
            g_idle_at = 0;
        end else begin
            count_charge(b);
        end
        split_capacity(reserve, usable);
        if (g_charge <= reserve) urem = 0;
        else urem = (g_charge - reserve > usable) ? usable : g_charge - reserve;
        vsoc = b.telemetry_valid ? window_soc(b.pack_mv) : 0;
        if (b.current_available) begin
            soc = (usable == 0) ? 0 : (urem * 100) / usable;
            if (soc > 100) soc = 100;
            rem = urem;
        end else begin
            soc = vsoc;
            rem = (usable * soc) / 100;
        end
        cons = (usable == 0) ? 0 : usable - urem;
        r.soc_percent = SOC_W'(soc);
        r.voltage_soc_percent = SOC_W'(vsoc);
        r.remaining_mah = CAP_W'(rem);
        r.consumed_mah = CAP_W'(cons);
        return r;
    endfunction

    function automatic void gauge_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] val);
        case (idx)
            CFG_CAPACITY: begin
                g_cap = val[15:0];
                g_charge = g_cap;
                g_frac = 0;
                g_idle_at = 0;
            end
            CFG_MIN_MV:   g_min_mv = val[15:0];
            CFG_MAX_MV:   g_max_mv = val[15:0];
            CFG_CELLS:    g_cells = val[4:0];
            CFG_RECAL_MA: g_idle_ma = val[19:0];
            CFG_RECAL_MS: g_idle_ms = val[23:0];
            default: ;
        endcase
    endfunction

    function automatic in_t tick(input bit cmd, input logic [31:0] ts, input bit ca,
                                 input bit tv, input logic [19:0] cur,
                                 input logic [15:0] mv);
        in_t b;
        b.command = cmd;
        b.timestamp_ms = ts;
        b.current_available = ca;
        b.telemetry_valid = tv;
        b.current_ma = cur;
        b.pack_mv = mv;
        return b;
    endfunction

    function automatic row_t beat_row(input in_t b);
        row_t r;
        r.is_cfg = 1'b0;
        r.idx = CFG_CAPACITY;
        r.val = '0;
        r.beat = b;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic row_t known_row(input in_t b, input out_t w);
        row_t r;
        r = beat_row(b);
        r.typed = 1'b1;
        r.want = w;
        return r;
    endfunction

    function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_W-1:0] val);
        row_t r;
        r = beat_row('0);
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    task automatic send_beat(input in_t b, input bit typed, input out_t want);
        out_t p;
        s_data <= b;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        p = gauge_predict(b);
        pending_reports.push_back(typed ? want : p);
        beats_sent++;
        if (b.command) refills++;
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_reports.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        gauge_config(idx, val);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Result side: stall pattern changes mode at random during the run.
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 2);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (stall_mode == 1 && $urandom_range(0, 99) < 3) begin
            stall_left <= $urandom_range(1, 40);
            m_ready <= 1'b0;
        end else if (stall_mode == 2) begin
            m_ready <= $urandom_range(0, 1);
        end else begin
            m_ready <= 1'b1;
        end
        if (cycles > RUN_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        out_t w;
        if (aresetn && m_valid && m_ready) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result beat %p", m_data);
            end else begin
                w = pending_reports.pop_front();
                if (m_data.soc_percent !== w.soc_percent
                    || m_data.voltage_soc_percent !== w.voltage_soc_percent
                    || m_data.remaining_mah !== w.remaining_mah
                    || m_data.consumed_mah !== w.consumed_mah) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Result %0d: expected soc %0d vsoc %0d rem %0d cons %0d",
                                 reports_seen, w.soc_percent, w.voltage_soc_percent,
                                 w.remaining_mah, w.consumed_mah);
                        $display("           got      soc %0d vsoc %0d rem %0d cons %0d",
                                 m_data.soc_percent, m_data.voltage_soc_percent,
                                 m_data.remaining_mah, m_data.consumed_mah);
                    end
                end
            end
        end
    end

    initial begin
        row_t            directed[$];
        logic [31:0]     now_ms;
        in_t             b;
        int              burst;
        int              per_phase;
        int unsigned     cells, vlo, vhi;

        g_cap = 0; g_min_mv = 0; g_max_mv = 65535; g_cells = 1;
        g_idle_ma = 0; g_idle_ms = 5000;
        g_charge = 0; g_last_ms = 0; g_frac = 0; g_idle_at = 0;

        // Reset values: no capacity, window spanning the whole curve.
        directed.push_back(known_row(tick(0, 0, 0, 1, 0, 4200), '{100, 100, 0, 0}));
        directed.push_back(known_row(tick(0, 0, 0, 1, 0, 16'hFFFF), '{100, 100, 0, 0}));
        directed.push_back(known_row(tick(0, 0, 0, 0, 0, 4000), '{0, 0, 0, 0}));
        directed.push_back(known_row(tick(0, 0, 1, 1, 0, 4000), '{0, 85, 0, 0}));
        directed.push_back(known_row(tick(1, 32'hFFFF_FFFF, 1, 1, 20'hFFFFF, 3200),
                                     '{0, 0, 0, 0}));
        // Zero cell count and a swapped, then empty, window.
        directed.push_back(cfg_row(CFG_CELLS, 0));
        directed.push_back(cfg_row(CFG_MIN_MV, 4200));
        directed.push_back(cfg_row(CFG_MAX_MV, 3300));
        directed.push_back(cfg_row(CFG_CAPACITY, 16'hFFFF));
        directed.push_back(beat_row(tick(0, 5, 0, 1, 0, 3900)));
        directed.push_back(cfg_row(CFG_MAX_MV, 4200));
        directed.push_back(beat_row(tick(0, 6, 1, 1, 100, 3900)));
        // Four cells, a real window and a short idle time.
        directed.push_back(cfg_row(CFG_CELLS, 4));
        directed.push_back(cfg_row(CFG_MIN_MV, 13200));
        directed.push_back(cfg_row(CFG_MAX_MV, 16400));
        directed.push_back(cfg_row(CFG_RECAL_MA, 50));
        directed.push_back(cfg_row(CFG_RECAL_MS, 100));
        directed.push_back(cfg_row(CFG_CAPACITY, 3000));
        directed.push_back(beat_row(tick(0, 0, 1, 1, 500, 15600)));
        directed.push_back(beat_row(tick(0, 10, 1, 1, 500, 15600)));
        directed.push_back(beat_row(tick(0, 3600010, 1, 1, 1000, 15400)));
        directed.push_back(beat_row(tick(0, 3600050, 1, 1, 10, 15400)));
        directed.push_back(beat_row(tick(0, 3600300, 1, 0, 20, 15400)));
        directed.push_back(beat_row(tick(0, 3600500, 1, 1, 0, 14000)));
        directed.push_back(beat_row(tick(0, 32'hF000_0000, 1, 1, 20'hFFFFF, 13000)));
        directed.push_back(beat_row(tick(1, 32'hF000_0001, 1, 1, 0, 16800)));
        directed.push_back(beat_row(tick(0, 32'hF000_0100, 0, 1, 300, 15000)));
        directed.push_back(beat_row(tick(0, 32'h0000_0200, 1, 1, 300, 15000)));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[k]) begin
            if (directed[k].is_cfg) begin
                drain();
                write_reg(directed[k].idx, directed[k].val);
            end else begin
                send_beat(directed[k].beat, directed[k].typed, directed[k].want);
            end
        end
        drain();

        now_ms = $urandom_range(1, 1000);
        for (int ph = 0; ph < 7; ph++) begin
            phases_run++;
            cells = (ph == 0) ? 1 : (ph == 1) ? 16 : (ph == 2) ? 31 : $urandom_range(1, 16);
            vlo = cells * $urandom_range(3150, 3600);
            vhi = cells * $urandom_range(3800, 4250);
            if (ph == 3) begin
                vlo = 0;
                vhi = 65535;
            end else if (ph == 4) begin
                vlo = 65535;
                vhi = 0;
            end
            write_reg(CFG_CELLS, cells);
            write_reg(CFG_MIN_MV, vlo[15:0]);
            write_reg(CFG_MAX_MV, vhi[15:0]);
            write_reg(CFG_RECAL_MA, (ph == 5) ? 20'hFFFFF : (ph == 6) ? 0 : $urandom_range(0, 2000));
            write_reg(CFG_RECAL_MS, (ph == 2) ? 24'hFFFFFF : (ph == 6) ? 0
                                               : $urandom_range(1, 20000));
            write_reg(CFG_CAPACITY, (ph == 1) ? 16'hFFFF : (ph == 5) ? 0
                                             : $urandom_range(500, 30000));
            per_phase = 100;
            burst = $urandom_range(1, 12);
            for (int n = 0; n < per_phase; n++) begin
                if ($urandom_range(0, 99) < 85) begin
                    case ($urandom_range(0, 3))
                        0:       now_ms = now_ms + $urandom_range(1, 500);
                        1:       now_ms = now_ms + $urandom_range(1000, 30000);
                        2:       now_ms = now_ms + $urandom_range(1000000, 20000000);
                        default: now_ms = now_ms + $urandom_range(1, 5000);
                    endcase
                    b = tick($urandom_range(0, 99) < 4, now_ms, $urandom_range(0, 9) != 0,
                             $urandom_range(0, 6) != 0, '0, '0);
                    if ($urandom_range(0, 1) == 0) b.current_ma = $urandom_range(0, g_idle_ma);
                    else b.current_ma = $urandom_range(0, 20'hFFFFF);
                    b.pack_mv = $urandom_range(vlo < vhi ? vlo : vhi, vlo < vhi ? vhi : vlo);
                end else begin
                    b = tick($urandom_range(0, 1), $urandom(), $urandom_range(0, 1),
                             $urandom_range(0, 1), $urandom_range(0, 20'hFFFFF),
                             $urandom_range(0, 16'hFFFF));
                    if ($urandom_range(0, 3) == 0) b.timestamp_ms = '0;
                end
                send_beat(b, 1'b0, '0);
                if (n == per_phase / 2 && ph == 3) begin
                    drain();
                end else if (--burst == 0) begin
                    burst = $urandom_range(1, 12);
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 25)) @(posedge aclk);
                end
            end
            drain();
        end

        repeat (SETTLE) @(posedge aclk);
        $display("Covered %0d beats (%0d refill commands) over %0d configuration phases,",
                 beats_sent, refills, phases_run);
        $display("with %0d result beats checked and %0d mismatches.", reports_seen, mismatches);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
